// ===== hdl/otasel_pkg.sv =====
package otasel_pkg;

    // otadata entry state words
    localparam logic [31:0] ST_NEW     = 32'h0000_0000;
    localparam logic [31:0] ST_PENDING = 32'h0000_0001;
    localparam logic [31:0] ST_INVALID = 32'h0000_0003;
    localparam logic [31:0] ST_ABORTED = 32'h0000_0004;

    // an erased sequence word reads as all ones
    localparam logic [31:0] SEQ_ERASED = 32'hFFFF_FFFF;

    // reflected CRC-32 polynomial of the sequence bytes, zero start, inverted output
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_XOR_OUT  = 32'hFFFF_FFFF;

    // boot_choice codes
    localparam logic [1:0] BOOT_SLOT0 = 2'd0;
    localparam logic [1:0] BOOT_SLOT1 = 2'd1;
    localparam logic [1:0] BOOT_HALT  = 2'd2;

    // chosen_entry codes
    localparam logic [1:0] ENTRY_FIRST  = 2'd0;
    localparam logic [1:0] ENTRY_SECOND = 2'd1;
    localparam logic [1:0] ENTRY_NONE   = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROLLBACK_EN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT0_BASE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT1_BASE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SIZE   = 3'd5;

    // configuration reset values
    localparam logic        RST_ROLLBACK_EN = 1'b1;
    localparam logic [31:0] RST_STACK_LOW   = 32'h2000_0000;
    localparam logic [31:0] RST_STACK_HIGH  = 32'h2004_0000;
    localparam logic [31:0] RST_SLOT0_BASE  = 32'h0000_C000;
    localparam logic [31:0] RST_SLOT1_BASE  = 32'h0008_0000;
    localparam logic [31:0] RST_SLOT_SIZE   = 32'h0007_4000;

    // one boot transaction as captured at the input
    typedef struct packed {
        logic [31:0] first_seq;
        logic [31:0] first_state;
        logic [31:0] first_crc;
        logic [31:0] second_seq;
        logic [31:0] second_state;
        logic [31:0] second_crc;
        logic [31:0] slot0_stack;
        logic [31:0] slot0_reset_vector;
        logic [31:0] slot1_stack;
        logic [31:0] slot1_reset_vector;
    } item_t;

    // one decision as presented at the output
    typedef struct packed {
        logic [1:0]  boot_choice;
        logic [1:0]  chosen_entry;
        logic        rewrite_first;
        logic [31:0] first_new_state;
        logic        rewrite_second;
        logic [31:0] second_new_state;
    } result_t;

    // CRC of a word with only bit k set, before the final inversion.
    // Evaluated at elaboration to build the XOR matrix below.
    function automatic logic [31:0] crc_unit(input int unsigned k);
        logic [31:0] c;
        logic [31:0] data;
        c    = '0;
        data = 32'd1 << k;
        for (int unsigned i = 0; i < 32; i++) begin
            c = ((c[0] ^ data[i]) != 1'b0) ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [31:0][31:0] crc_matrix();
        logic [31:0][31:0] m;
        for (int unsigned k = 0; k < 32; k++) begin
            m[k] = crc_unit(k);
        end
        return m;
    endfunction

    localparam logic [31:0][31:0] CRC_COL = crc_matrix();

    // CRC is linear with zero start: XOR the columns of the set bits
    function automatic logic [31:0] seq_crc(input logic [31:0] seq);
        logic [31:0] c;
        c = '0;
        for (int unsigned k = 0; k < 32; k++) begin
            if (seq[k]) begin
                c = c ^ CRC_COL[k];
            end
        end
        return c ^ CRC_XOR_OUT;
    endfunction

endpackage

// ===== hdl/ota_boot_slot_selector.sv =====
// Dual-bank boot slot selector with rollback. Each input transaction carries both
// otadata entries and the first two vector words of both image slots; each one
// yields exactly one result transaction with the slot to boot (or halt), the
// active entry, and the state words to write back. The block is a two-register
// pipeline (input register, result register) and takes one transaction per
// clock while the pipe is not stalled; a transaction passes the input register
// and then the result register, and the pipe stalls only while m_ready is low.
// Configuration registers are written through cfg_valid/cfg_ready (always
// ready) and must only change while no transaction is in flight.
module ota_boot_slot_selector (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [otasel_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_data,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [31:0]                      s_first_seq,
    input  logic [31:0]                      s_first_state,
    input  logic [31:0]                      s_first_crc,
    input  logic [31:0]                      s_second_seq,
    input  logic [31:0]                      s_second_state,
    input  logic [31:0]                      s_second_crc,
    input  logic [31:0]                      s_slot0_stack,
    input  logic [31:0]                      s_slot0_reset_vector,
    input  logic [31:0]                      s_slot1_stack,
    input  logic [31:0]                      s_slot1_reset_vector,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_boot_choice,
    output logic [1:0]                       m_chosen_entry,
    output logic                             m_rewrite_first,
    output logic [31:0]                      m_first_new_state,
    output logic                             m_rewrite_second,
    output logic [31:0]                      m_second_new_state
);

    // configuration registers
    logic        rollback_en_reg;
    logic [31:0] stack_low_reg;
    logic [31:0] stack_high_reg;
    logic [31:0] slot0_base_reg;
    logic [31:0] slot1_base_reg;
    logic [31:0] slot_size_reg;

    // pipeline registers
    logic                  in_valid_reg;
    otasel_pkg::item_t     in_item_reg;
    logic                  out_valid_reg;
    otasel_pkg::result_t   out_res_reg;
    otasel_pkg::result_t   out_res_next;

    logic out_free;
    logic in_load;

    // decision terms
    logic [31:0] st0_abt, st1_abt;
    logic        abort0, abort1;
    logic        ok0, ok1;
    logic        boot0, boot1;
    logic        pick_first, pick_second;
    logic [31:0] win_seq, win_state;
    logic        win_slot;
    logic        promote;
    logic        win_boot, alt_boot;

    assign cfg_ready = 1'b1;

    // configuration writes; indexes past the list are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rollback_en_reg <= otasel_pkg::RST_ROLLBACK_EN;
            stack_low_reg   <= otasel_pkg::RST_STACK_LOW;
            stack_high_reg  <= otasel_pkg::RST_STACK_HIGH;
            slot0_base_reg  <= otasel_pkg::RST_SLOT0_BASE;
            slot1_base_reg  <= otasel_pkg::RST_SLOT1_BASE;
            slot_size_reg   <= otasel_pkg::RST_SLOT_SIZE;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                otasel_pkg::CFG_ROLLBACK_EN: rollback_en_reg <= cfg_data[0];
                otasel_pkg::CFG_STACK_LOW:   stack_low_reg   <= cfg_data;
                otasel_pkg::CFG_STACK_HIGH:  stack_high_reg  <= cfg_data;
                otasel_pkg::CFG_SLOT0_BASE:  slot0_base_reg  <= cfg_data;
                otasel_pkg::CFG_SLOT1_BASE:  slot1_base_reg  <= cfg_data;
                otasel_pkg::CFG_SLOT_SIZE:   slot_size_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipe flow: each stage moves when the one after it is free
    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_free;
    assign in_load  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_item_reg.first_seq          <= s_first_seq;
            in_item_reg.first_state        <= s_first_state;
            in_item_reg.first_crc          <= s_first_crc;
            in_item_reg.second_seq         <= s_second_seq;
            in_item_reg.second_state       <= s_second_state;
            in_item_reg.second_crc         <= s_second_crc;
            in_item_reg.slot0_stack        <= s_slot0_stack;
            in_item_reg.slot0_reset_vector <= s_slot0_reset_vector;
            in_item_reg.slot1_stack        <= s_slot1_stack;
            in_item_reg.slot1_reset_vector <= s_slot1_reset_vector;
        end
    end

    // vector table sanity: stack in RAM window, thumb reset vector inside a slot
    function automatic logic in_slot(input logic [31:0] pc, input logic [31:0] base,
                                     input logic [31:0] size);
        logic [32:0] slot_end;
        slot_end = {1'b0, base} + {1'b0, size};
        return (pc >= base) && ({1'b0, pc} < slot_end);
    endfunction

    function automatic logic is_bootable(input logic [31:0] sp, input logic [31:0] rv,
                                         input logic [31:0] lo, input logic [31:0] hi,
                                         input logic [31:0] b0, input logic [31:0] b1,
                                         input logic [31:0] size);
        logic [31:0] pc;
        pc = {rv[31:1], 1'b0};
        return (sp >= lo) && (sp <= hi) && rv[0]
            && (in_slot(pc, b0, size) || in_slot(pc, b1, size));
    endfunction

    // rollback: a pending entry is aborted
    assign abort0  = rollback_en_reg && (in_item_reg.first_state == otasel_pkg::ST_PENDING);
    assign abort1  = rollback_en_reg && (in_item_reg.second_state == otasel_pkg::ST_PENDING);
    assign st0_abt = abort0 ? otasel_pkg::ST_ABORTED : in_item_reg.first_state;
    assign st1_abt = abort1 ? otasel_pkg::ST_ABORTED : in_item_reg.second_state;

    // entry validity
    assign ok0 = (in_item_reg.first_seq != otasel_pkg::SEQ_ERASED)
              && (st0_abt != otasel_pkg::ST_INVALID) && (st0_abt != otasel_pkg::ST_ABORTED)
              && (in_item_reg.first_crc == otasel_pkg::seq_crc(in_item_reg.first_seq));
    assign ok1 = (in_item_reg.second_seq != otasel_pkg::SEQ_ERASED)
              && (st1_abt != otasel_pkg::ST_INVALID) && (st1_abt != otasel_pkg::ST_ABORTED)
              && (in_item_reg.second_crc == otasel_pkg::seq_crc(in_item_reg.second_seq));

    assign boot0 = is_bootable(in_item_reg.slot0_stack, in_item_reg.slot0_reset_vector,
                               stack_low_reg, stack_high_reg,
                               slot0_base_reg, slot1_base_reg, slot_size_reg);
    assign boot1 = is_bootable(in_item_reg.slot1_stack, in_item_reg.slot1_reset_vector,
                               stack_low_reg, stack_high_reg,
                               slot0_base_reg, slot1_base_reg, slot_size_reg);

    // higher sequence wins, tie goes to entry zero
    assign pick_first  = ok0 && (!ok1 || (in_item_reg.first_seq >= in_item_reg.second_seq));
    assign pick_second = !pick_first && ok1;

    assign win_seq   = pick_first ? in_item_reg.first_seq : in_item_reg.second_seq;
    assign win_state = pick_first ? st0_abt : st1_abt;
    // slot is (seq - 1) mod 2, i.e. the inverted low bit
    assign win_slot  = !win_seq[0];
    assign promote   = rollback_en_reg && (win_state == otasel_pkg::ST_NEW)
                    && (pick_first || pick_second);
    assign win_boot  = win_slot ? boot1 : boot0;
    assign alt_boot  = win_slot ? boot0 : boot1;

    // result assembly
    always_comb begin
        out_res_next.rewrite_first    = abort0;
        out_res_next.first_new_state  = st0_abt;
        out_res_next.rewrite_second   = abort1;
        out_res_next.second_new_state = st1_abt;
        priority if (pick_first) begin
            out_res_next.chosen_entry = otasel_pkg::ENTRY_FIRST;
        end else if (pick_second) begin
            out_res_next.chosen_entry = otasel_pkg::ENTRY_SECOND;
        end else begin
            out_res_next.chosen_entry = otasel_pkg::ENTRY_NONE;
        end

        if (promote && pick_first) begin
            out_res_next.rewrite_first   = 1'b1;
            out_res_next.first_new_state = otasel_pkg::ST_PENDING;
        end
        if (promote && pick_second) begin
            out_res_next.rewrite_second   = 1'b1;
            out_res_next.second_new_state = otasel_pkg::ST_PENDING;
        end

        if (!pick_first && !pick_second) begin
            // no valid entry: probe slot zero, then slot one
            priority if (boot0) begin
                out_res_next.boot_choice = otasel_pkg::BOOT_SLOT0;
            end else if (boot1) begin
                out_res_next.boot_choice = otasel_pkg::BOOT_SLOT1;
            end else begin
                out_res_next.boot_choice = otasel_pkg::BOOT_HALT;
            end
        end else begin
            priority if (win_boot) begin
                out_res_next.boot_choice = win_slot ? otasel_pkg::BOOT_SLOT1
                                                    : otasel_pkg::BOOT_SLOT0;
            end else if (alt_boot) begin
                out_res_next.boot_choice = win_slot ? otasel_pkg::BOOT_SLOT0
                                                    : otasel_pkg::BOOT_SLOT1;
            end else begin
                out_res_next.boot_choice = otasel_pkg::BOOT_HALT;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && in_valid_reg) begin
            out_res_reg <= out_res_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_boot_choice      = out_res_reg.boot_choice;
    assign m_chosen_entry     = out_res_reg.chosen_entry;
    assign m_rewrite_first    = out_res_reg.rewrite_first;
    assign m_first_new_state  = out_res_reg.first_new_state;
    assign m_rewrite_second   = out_res_reg.rewrite_second;
    assign m_second_new_state = out_res_reg.second_new_state;

`ifndef NO_ASSERTIONS
    // a held transaction in the input register is never dropped
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg)
        else $error("input transaction lost while result stalled");

    // an accepted input always reaches the result register
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_free |=> out_valid_reg)
        else $error("transaction did not advance to result register");

    // halt code is the only out-of-slot choice, and no entry code 3 is given
    a_choice_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_boot_choice != 2'd3) && (m_chosen_entry != 2'd3))
        else $error("illegal result code");

    // promotion of entry zero to pending only when it is the chosen entry
    a_promote_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rewrite_first && (m_first_new_state == otasel_pkg::ST_PENDING)
        |-> (m_chosen_entry == otasel_pkg::ENTRY_FIRST))
        else $error("entry zero promoted without being chosen");

    // without an active entry the only rewrite of the second entry is an abort
    a_none_abort: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_chosen_entry == otasel_pkg::ENTRY_NONE) && m_rewrite_second
        |-> (m_second_new_state == otasel_pkg::ST_ABORTED))
        else $error("rewrite other than abort with no active entry");
`endif

endmodule
